// ===== rtl/rtmh_pkg.sv =====
// Shared types and codes for the min-hop routing table.
`timescale 1ns / 1ps

package rtmh_pkg;

    // Operation codes on the mode field; any other code reads as lookup
    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_DEL = 2'd1;
    localparam logic [1:0] MODE_LKP = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_IMPROVED  = 3'd1;
    localparam logic [2:0] ST_KEPT      = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_DELETED   = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_FOUND     = 3'd6;

    // One stored route
    typedef struct packed {
        logic [7:0] dest;
        logic [7:0] hop;
        logic [7:0] hops;
    } route_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DEL_WR
    } state_t;

endpackage

// ===== rtl/rtmh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rtmh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/route_table_min_hop_core.sv =====
// Top level of the min-hop routing table: search sequencer around the route RAM.
`timescale 1ns / 1ps

// Routing table of up to TABLE_ENTRIES routes kept in one synchronous RAM.
// An operation is taken when start is high and busy is low. Busy then stays
// high until the result is out. The RAM is searched one entry per cycle, in
// order, and a hit ends the search early. A delete that hits then passes
// through S_DEL_WR, which writes the last entry, read in S_DECIDE, into the
// freed slot. The result shows on status, found_gateway, found_hops and
// entry_count for exactly the one cycle in which done is high, and must be
// taken then: there is no back-pressure on the result side. A new operation
// may be started in that same cycle. Table contents need no clearing after
// reset: only entries below the count are ever read.
module route_table_min_hop_core
    import rtmh_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] mode,
    input  logic [7:0] dest_addr,
    input  logic [7:0] gateway_addr,
    input  logic [7:0] hop_count,
    output logic       done,
    output logic [2:0] status,
    output logic [7:0] found_gateway,
    output logic [7:0] found_hops,
    output logic [4:0] entry_count
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    // Control registers
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg,  scan_next;
    logic          pend_reg,  pend_next;
    logic          hit_reg,   hit_next;
    logic          done_reg,  done_next;

    // Payload registers
    logic [1:0]    mode_reg,     mode_next;
    logic [7:0]    dest_reg,     dest_next;
    logic [7:0]    hop_reg,      hop_next;
    logic [7:0]    hops_reg,     hops_next;
    logic [IW-1:0] idx_reg,      idx_next;
    route_t        ent_reg,      ent_next;
    logic [2:0]    status_reg,   status_next;
    logic [7:0]    out_hop_reg,  out_hop_next;
    logic [7:0]    out_hops_reg, out_hops_next;

    // RAM port signals
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    route_t        wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    route_t        rd_data;
    logic [CW-1:0] last_cnt;
    logic [CW+4:0] cnt_ext;

    rtmh_ram #(
        .WIDTH ($bits(route_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign last_cnt = count_reg - CW'(1);

    // Sequencer: scan, decide, optional move-last for delete
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        hit_next      = hit_reg;
        done_next     = 1'b0;
        mode_next     = mode_reg;
        dest_next     = dest_reg;
        hop_next      = hop_reg;
        hops_next     = hops_reg;
        idx_next      = idx_reg;
        ent_next      = ent_reg;
        status_next   = status_reg;
        out_hop_next  = out_hop_reg;
        out_hops_next = out_hops_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = '{dest: dest_reg, hop: hop_reg, hops: hops_reg};
        rd_en         = 1'b0;
        rd_addr       = scan_reg[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    dest_next  = dest_addr;
                    hop_next   = gateway_addr;
                    hops_next  = hop_count;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // compare the entry read last cycle; on a miss, issue the next read while entries remain
                if (pend_reg && (rd_data.dest == dest_reg))
                begin
                    hit_next   = 1'b1;
                    ent_next   = rd_data;
                    pend_next  = 1'b0;
                    state_next = S_DECIDE;
                end
                else if (scan_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg[IW-1:0];
                    idx_next  = scan_reg[IW-1:0];
                    pend_next = 1'b1;
                    scan_next = scan_reg + CW'(1);
                end
                else
                begin
                    hit_next   = 1'b0;
                    pend_next  = 1'b0;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next    = S_IDLE;
                done_next     = 1'b1;
                out_hop_next  = 8'd0;
                out_hops_next = 8'd0;
                case (mode_reg)
                    MODE_ADD:
                    begin
                        if (hit_reg)
                        begin
                            if (hops_reg < ent_reg.hops)
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = idx_reg;
                                status_next   = ST_IMPROVED;
                                out_hop_next  = hop_reg;
                                out_hops_next = hops_reg;
                            end
                            else
                            begin
                                status_next   = ST_KEPT;
                                out_hop_next  = ent_reg.hop;
                                out_hops_next = ent_reg.hops;
                            end
                        end
                        else if (count_reg != FULL_COUNT)
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = count_reg[IW-1:0];
                            count_next    = count_reg + CW'(1);
                            status_next   = ST_INSERTED;
                            out_hop_next  = hop_reg;
                            out_hops_next = hops_reg;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    MODE_DEL:
                    begin
                        if (hit_reg)
                        begin
                            // fetch the last route to refill the freed slot
                            rd_en       = 1'b1;
                            rd_addr     = last_cnt[IW-1:0];
                            done_next   = 1'b0;
                            status_next = ST_DELETED;
                            state_next  = S_DEL_WR;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            status_next   = ST_FOUND;
                            out_hop_next  = ent_reg.hop;
                            out_hops_next = ent_reg.hops;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                endcase
            end

            S_DEL_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = rd_data;
                count_next = last_cnt;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            done_reg  <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        dest_reg     <= dest_next;
        hop_reg      <= hop_next;
        hops_reg     <= hops_next;
        idx_reg      <= idx_next;
        ent_reg      <= ent_next;
        status_reg   <= status_next;
        out_hop_reg  <= out_hop_next;
        out_hops_reg <= out_hops_next;
    end

    // Outputs
    assign cnt_ext        = {5'd0, count_reg};
    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found_gateway  = out_hop_reg;
    assign found_hops     = out_hops_reg;
    assign entry_count    = cnt_ext[4:0];

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("route count beyond table size");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result beat while sequencer still busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result beat held longer than one cycle");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> $stable(count_reg))
        else $error("route count changed during search");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the min-hop routing table core.
`timescale 1ns / 1ps

module tb_top
    import rtmh_pkg::*;
();

    // Mode 3 has no name in the package; the core decodes it as a lookup
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         ROUTE_SLOTS = 16;
    localparam int         DRAIN_CYCLES = 30;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PRINT_CAP = 20;

    // One operation beat and one result beat
    typedef struct {
        logic [1:0] mode;
        logic [7:0] dest;
        logic [7:0] nh;
        logic [7:0] hc;
    } route_op_t;

    typedef struct {
        logic [2:0] status;
        logic [7:0] nh;
        logic [7:0] hops;
        logic [4:0] count;
    } route_reply_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [1:0] mode = MODE_LKP;
    logic [7:0] dest_addr = 8'd0;
    logic [7:0] gateway_addr = 8'd0;
    logic [7:0] hop_count = 8'd0;
    logic       busy;
    logic       done;
    logic [2:0] status;
    logic [7:0] found_gateway;
    logic [7:0] found_hops;
    logic [4:0] entry_count;

    route_op_t    pending_ops[$];
    route_reply_t expected_routes[$];
    route_op_t    cur_op;

    // Shadow of the table contents
    route_t       shadow_tbl[ROUTE_SLOTS];
    int           shadow_cnt = 0;
    int           peak_cnt = 0;

    int           mismatches = 0;
    int           ops_sent = 0;
    int           results_seen = 0;
    int           status_hits[7];
    int           gap_left = 0;
    int           burst_left = 0;
    bit           idle_on = 1'b1;
    int           cycle_cnt = 0;

    route_table_min_hop_core #(
        .TABLE_ENTRIES (ROUTE_SLOTS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .dest_addr      (dest_addr),
        .gateway_addr   (gateway_addr),
        .hop_count      (hop_count),
        .done           (done),
        .status         (status),
        .found_gateway  (found_gateway),
        .found_hops     (found_hops),
        .entry_count    (entry_count)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Apply one operation to the shadow table and work out its result
    function automatic void route_table_apply(input route_op_t op, output route_reply_t rep);
        int idx;
        int last;
        idx = -1;
        rep.status = ST_NOT_FOUND;
        rep.nh = 8'd0;
        rep.hops = 8'd0;
        for (int i = 0; i < shadow_cnt; i++)
            if (idx < 0 && shadow_tbl[i].dest == op.dest)
                idx = i;
        case (op.mode)
            MODE_ADD:
            begin
                if (idx >= 0)
                begin
                    // strictly shorter path replaces the stored route
                    if (op.hc < shadow_tbl[idx].hops)
                    begin
                        shadow_tbl[idx].hop = op.nh;
                        shadow_tbl[idx].hops = op.hc;
                        rep.status = ST_IMPROVED;
                    end
                    else
                        rep.status = ST_KEPT;
                    rep.nh = shadow_tbl[idx].hop;
                    rep.hops = shadow_tbl[idx].hops;
                end
                else if (shadow_cnt < ROUTE_SLOTS)
                begin
                    shadow_tbl[shadow_cnt] = '{dest: op.dest, hop: op.nh, hops: op.hc};
                    shadow_cnt++;
                    rep.status = ST_INSERTED;
                    rep.nh = op.nh;
                    rep.hops = op.hc;
                end
                else
                    rep.status = ST_FULL;
            end
            MODE_DEL:
            begin
                // last entry fills the hole
                if (idx >= 0)
                begin
                    last = shadow_cnt - 1;
                    shadow_tbl[idx] = shadow_tbl[last];
                    shadow_cnt = last;
                    rep.status = ST_DELETED;
                end
            end
            default:
            begin
                if (idx >= 0)
                begin
                    rep.status = ST_FOUND;
                    rep.nh = shadow_tbl[idx].hop;
                    rep.hops = shadow_tbl[idx].hops;
                end
            end
        endcase
        rep.count = 5'(shadow_cnt);
        if (shadow_cnt > peak_cnt)
            peak_cnt = shadow_cnt;
        status_hits[rep.status]++;
    endfunction

    function automatic void queue_op(logic [1:0] m, logic [7:0] d, logic [7:0] n, logic [7:0] h);
        route_op_t op;
        op.mode = m;
        op.dest = d;
        op.nh = n;
        op.hc = h;
        pending_ops.push_back(op);
    endfunction

    // Idle length before the next beat: mostly short, a few long, some bursts with none
    function automatic int pick_gap();
        int r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(20, 150);
            idle_on = ($urandom_range(0, 2) != 0);
        end
        burst_left--;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Stimulus: directed corner cases, then random blocks
    initial
    begin
        int r;
        int bias;
        int base;
        int span;
        logic [1:0] m;
        logic [7:0] d;
        logic [7:0] h;

        // empty table, extremes of every field, equal and shorter paths, spare mode
        queue_op(MODE_LKP, 8'h5A, 8'h00, 8'h00);
        queue_op(MODE_DEL, 8'h5A, 8'h00, 8'h00);
        queue_op(MODE_ADD, 8'h00, 8'hFF, 8'hFF);
        queue_op(MODE_ADD, 8'hFF, 8'h00, 8'h00);
        queue_op(MODE_ADD, 8'h00, 8'h11, 8'hFF);
        queue_op(MODE_ADD, 8'h00, 8'h22, 8'h10);
        queue_op(MODE_SPARE, 8'h00, 8'h00, 8'h00);
        queue_op(MODE_DEL, 8'h00, 8'h00, 8'h00);
        // fill the table, then new route refused and existing one improved while full
        for (int i = 1; i < ROUTE_SLOTS; i++)
            queue_op(MODE_ADD, 8'(8'h10 + i), 8'(i), 8'(8'h80 + i));
        queue_op(MODE_ADD, 8'h42, 8'hA5, 8'h01);
        queue_op(MODE_ADD, 8'h13, 8'h5A, 8'h01);
        queue_op(MODE_ADD, 8'hFF, 8'h77, 8'h00);
        queue_op(MODE_LKP, 8'h42, 8'h00, 8'h00);

        // random blocks, each leaning toward filling, draining or a mix,
        // with addresses mostly from a narrow window so hits are common
        for (int blk = 0; blk < 19; blk++)
        begin
            bias = $urandom_range(0, 2);
            base = $urandom_range(0, 255);
            span = $urandom_range(3, 28);
            for (int k = 0; k < 100; k++)
            begin
                r = $urandom_range(0, 99);
                case (bias)
                    0: m = (r < 70) ? MODE_ADD : (r < 80) ? MODE_DEL :
                           (r < 97) ? MODE_LKP : MODE_SPARE;
                    1: m = (r < 25) ? MODE_ADD : (r < 75) ? MODE_DEL :
                           (r < 97) ? MODE_LKP : MODE_SPARE;
                    default: m = (r < 45) ? MODE_ADD : (r < 70) ? MODE_DEL :
                                 (r < 95) ? MODE_LKP : MODE_SPARE;
                endcase
                if ($urandom_range(0, 9) == 0)
                    d = 8'($urandom_range(0, 255));
                else
                    d = 8'(base + $urandom_range(0, span - 1));
                if ($urandom_range(0, 3) == 0)
                    h = 8'($urandom_range(0, 255));
                else
                    h = 8'($urandom_range(0, 12));
                queue_op(m, d, 8'($urandom_range(0, 255)), h);
            end
        end
    end

    // Driver: issues queued beats with random idle cycles between them
    always @(posedge clk or negedge rst_n)
    begin
        route_reply_t rep;
        logic go;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            go = start;
            if (start && !busy)
            begin
                route_table_apply(cur_op, rep);
                expected_routes.push_back(rep);
                ops_sent++;
                go = 1'b0;
                gap_left = pick_gap();
            end
            if (!go)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_ops.size() > 0)
                begin
                    cur_op = pending_ops.pop_front();
                    mode <= cur_op.mode;
                    dest_addr <= cur_op.dest;
                    gateway_addr <= cur_op.nh;
                    hop_count <= cur_op.hc;
                    go = 1'b1;
                end
            end
            start <= go;
        end
    end

    // Monitor: each done beat is checked against the oldest expectation
    always @(posedge clk)
    begin
        route_reply_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_routes.size() == 0)
                flag_mismatch("unexpected result, status", status, -1);
            else
            begin
                want = expected_routes.pop_front();
                if (status !== want.status)
                    flag_mismatch("status", status, want.status);
                if (found_gateway !== want.nh)
                    flag_mismatch("found_gateway", found_gateway, want.nh);
                if (found_hops !== want.hops)
                    flag_mismatch("found_hops", found_hops, want.hops);
                if (entry_count !== want.count)
                    flag_mismatch("entry_count", entry_count, want.count);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     expected_routes.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // End of run: everything issued and answered, then a short drain
    initial
    begin
        @(posedge rst_n);
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || start || expected_routes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Ran %0d operations, %0d results checked, table peaked at %0d routes",
                 ops_sent, results_seen, peak_cnt);
        $display("Status mix: ins %0d, impr %0d, kept %0d, full %0d, del %0d, miss %0d, hit %0d",
                 status_hits[ST_INSERTED], status_hits[ST_IMPROVED], status_hits[ST_KEPT],
                 status_hits[ST_FULL], status_hits[ST_DELETED], status_hits[ST_NOT_FOUND],
                 status_hits[ST_FOUND]);
        if (mismatches == 0 && expected_routes.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
